### src/pam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pam_pkg
// Shared types and constants of the phase anomaly monitor.
// ----------------------------------------------------------------------------
package pam_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PHASE_W   = 16;
    localparam int unsigned GAIN_W    = 13;
    localparam int unsigned GAIN_FRAC = 12;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIMIT_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL        = 3'd5;

    // register reset values
    localparam logic [PHASE_W-1:0] RST_OVER_LIMIT_LEVEL = 16'd1000;
    localparam logic [PHASE_W-1:0] RST_CONFIRM_COUNT    = 16'd10;
    localparam logic [PHASE_W-1:0] RST_RISE_THRESHOLD   = 16'd100;
    localparam logic [PHASE_W-1:0] RST_INHIBIT_LENGTH   = 16'd50;
    localparam logic [GAIN_W-1:0]  RST_FILTER_GAIN      = 13'd41;
    localparam logic [PHASE_W-1:0] RST_LOW_LEVEL        = 16'd300;

    // item operation codes
    localparam logic OP_SAMPLE     = 1'b0;
    localparam logic OP_RESET_BASE = 1'b1;

    typedef struct packed {
        logic signed [PHASE_W-1:0] over_limit_level;
        logic        [PHASE_W-1:0] confirm_count;
        logic signed [PHASE_W-1:0] rise_threshold;
        logic        [PHASE_W-1:0] inhibit_length;
        logic        [GAIN_W-1:0]  filter_gain;
        logic signed [PHASE_W-1:0] low_level;
    } t_cfg;

    typedef struct packed {
        logic removed;
        logic warn;
        logic rise;
        logic inhibit;
        logic low;
        logic locked;
        logic ready;
    } t_flags;

endpackage
`default_nettype wire

### src/phase_anomaly_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phase_anomaly_monitor
// Watches control-period phase samples for load removal, sudden rise and
// low phase, with a q12 low-pass baseline and an inhibit hold.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  in       | to block  | i_in_valid / o_in_stall   | i_op, i_phase
//  out      | from block| o_out_valid / i_out_stall | o_*_flag, o_baseline_out
//  cfg      | to block  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; an item goes
// from its input transfer into the input register, then through one update
// pass into the state/result registers, where its result is valid. the
// baseline/flag state loop closes combinationally through one 16x14
// multiply and a few compares.
// i_rst_n is synchronous, active low; it clears state, flags and the
// registers to their documented defaults.
// an output stall freezes the result and backs up into the input register;
// o_in_stall only rises when that register holds an item that cannot move.
// ----------------------------------------------------------------------------
module phase_anomaly_monitor #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // sample channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_op,
    input  wire logic signed [pam_pkg::PHASE_W-1:0] i_phase,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_removed_flag,
    output logic                                    o_warn_flag,
    output logic                                    o_rise_flag,
    output logic                                    o_inhibit_flag,
    output logic                                    o_low_flag,
    output logic                                    o_locked_flag,
    output logic                                    o_ready_flag,
    output logic signed [pam_pkg::PHASE_W-1:0]      o_baseline_out,
    // configuration channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [pam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pam_pkg::PHASE_W-1:0]        i_cfg_data
);

    pam_pkg::t_cfg cfg;

    // input register
    logic                               r_in_valid;
    logic                               r_in_op;
    logic signed [pam_pkg::PHASE_W-1:0] r_in_phase;

    // state, which doubles as the result register
    logic                               r_out_valid;
    pam_pkg::t_flags                    r_flags;
    logic signed [pam_pkg::PHASE_W-1:0] r_baseline;
    logic [COUNT_WIDTH-1:0]             r_count;
    logic [pam_pkg::PHASE_W-1:0]        r_hold;

    pam_pkg::t_flags                    n_flags;
    logic signed [pam_pkg::PHASE_W-1:0] n_baseline;
    logic [COUNT_WIDTH-1:0]             n_count;
    logic [pam_pkg::PHASE_W-1:0]        n_hold;

    logic adv;       // held item moves through the update into the result
    logic in_take;   // input transfer

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    pam_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pam_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_upd (
        .i_op       (r_in_op),
        .i_phase    (r_in_phase),
        .i_cfg      (cfg),
        .i_flags    (r_flags),
        .i_baseline (r_baseline),
        .i_count    (r_count),
        .i_hold     (r_hold),
        .o_flags    (n_flags),
        .o_baseline (n_baseline),
        .o_count    (n_count),
        .o_hold     (n_hold)
    );

    // result slot is free when empty or being taken this cycle
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op    <= i_op;
            r_in_phase <= i_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_baseline  <= '0;
            r_count     <= '0;
            r_hold      <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
                r_baseline  <= n_baseline;
                r_count     <= n_count;
                r_hold      <= n_hold;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // state only moves on adv, so it holds steady while a result is stalled
    assign o_out_valid    = r_out_valid;
    assign o_removed_flag = r_flags.removed;
    assign o_warn_flag    = r_flags.warn;
    assign o_rise_flag    = r_flags.rise;
    assign o_inhibit_flag = r_flags.inhibit;
    assign o_low_flag     = r_flags.low;
    assign o_locked_flag  = r_flags.locked;
    assign o_ready_flag   = r_flags.ready;
    assign o_baseline_out = r_baseline;

endmodule
`default_nettype wire

### src/pam_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pam_cfg_regs
// Configuration register file, written through a valid port with index and data.
// ----------------------------------------------------------------------------
module pam_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [pam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pam_pkg::PHASE_W-1:0]     i_cfg_data,
    output pam_pkg::t_cfg                        o_cfg
);

    pam_pkg::t_cfg r_cfg;
    pam_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pam_pkg::CFG_OVER_LIMIT_LEVEL: n_cfg.over_limit_level = i_cfg_data;
                pam_pkg::CFG_CONFIRM_COUNT:    n_cfg.confirm_count    = i_cfg_data;
                pam_pkg::CFG_RISE_THRESHOLD:   n_cfg.rise_threshold   = i_cfg_data;
                pam_pkg::CFG_INHIBIT_LENGTH:   n_cfg.inhibit_length   = i_cfg_data;
                pam_pkg::CFG_FILTER_GAIN:
                    n_cfg.filter_gain = i_cfg_data[pam_pkg::GAIN_W-1:0];
                pam_pkg::CFG_LOW_LEVEL:        n_cfg.low_level        = i_cfg_data;
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.over_limit_level <= pam_pkg::RST_OVER_LIMIT_LEVEL;
            r_cfg.confirm_count    <= pam_pkg::RST_CONFIRM_COUNT;
            r_cfg.rise_threshold   <= pam_pkg::RST_RISE_THRESHOLD;
            r_cfg.inhibit_length   <= pam_pkg::RST_INHIBIT_LENGTH;
            r_cfg.filter_gain      <= pam_pkg::RST_FILTER_GAIN;
            r_cfg.low_level        <= pam_pkg::RST_LOW_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### src/pam_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pam_update
// One-sample update of counters, baseline filter and anomaly flags.
// ----------------------------------------------------------------------------
module pam_update #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                               i_op,
    input  wire logic signed [pam_pkg::PHASE_W-1:0] i_phase,
    input  wire pam_pkg::t_cfg                      i_cfg,
    input  wire pam_pkg::t_flags                    i_flags,
    input  wire logic signed [pam_pkg::PHASE_W-1:0] i_baseline,
    input  wire logic [COUNT_WIDTH-1:0]             i_count,
    input  wire logic [pam_pkg::PHASE_W-1:0]        i_hold,
    output pam_pkg::t_flags                         o_flags,
    output logic signed [pam_pkg::PHASE_W-1:0]      o_baseline,
    output logic [COUNT_WIDTH-1:0]                  o_count,
    output logic [pam_pkg::PHASE_W-1:0]             o_hold
);

    localparam int unsigned CMP_W  = (COUNT_WIDTH > pam_pkg::PHASE_W) ?
                                     COUNT_WIDTH : pam_pkg::PHASE_W;
    localparam int unsigned PROD_W = pam_pkg::PHASE_W + pam_pkg::GAIN_W + 1;
    localparam int unsigned PW     = pam_pkg::PHASE_W;

    logic signed [PW-1:0]     oll;
    logic signed [PW-1:0]     rth;
    logic signed [PW-1:0]     lowl;
    logic                     over;
    logic [COUNT_WIDTH-1:0]   cnt1;
    logic                     removed1;
    logic signed [PW-1:0]     base1;
    logic signed [PW-1:0]     delta;
    logic                     trig;
    logic                     locked1;
    logic signed [PROD_W-1:0] prod;
    logic signed [PW-1:0]     base2;
    logic signed [PW-1:0]     chk;
    logic                     low1;
    logic [PW-1:0]            hold1;
    logic [PW-1:0]            hold2;
    logic                     inh1;

    assign oll  = i_cfg.over_limit_level;
    assign rth  = i_cfg.rise_threshold;
    assign lowl = i_cfg.low_level;

    // over-limit run, saturating
    assign over     = (i_phase >= oll);
    assign cnt1     = !over ? '0 :
                      ((&i_count) ? i_count : i_count + COUNT_WIDTH'(1));
    assign removed1 = over &&
                      (i_flags.removed || (CMP_W'(cnt1) >= CMP_W'(i_cfg.confirm_count)));

    // first sample seeds the baseline, then sudden-rise check
    assign base1   = i_flags.ready ? i_baseline : i_phase;
    assign delta   = i_phase - base1;
    assign trig    = !i_flags.locked && (delta > rth);
    assign locked1 = i_flags.locked || trig;

    // q12 low-pass: floor(delta * gain / 4096), low 16 bits
    assign prod  = PROD_W'(delta) * PROD_W'($signed({1'b0, i_cfg.filter_gain}));
    assign base2 = locked1 ? base1 :
                   base1 + prod[pam_pkg::GAIN_FRAC +: PW];

    assign low1  = (i_phase < lowl);
    assign inh1  = i_flags.inhibit || trig || low1;
    assign hold1 = (trig || low1) ? i_cfg.inhibit_length : i_hold;
    assign hold2 = hold1 - PW'(1);
    assign chk   = i_phase - base2;

    always_comb begin
        o_flags    = '0;
        o_baseline = i_phase;
        o_count    = i_count;
        o_hold     = '0;
        if (i_op == pam_pkg::OP_RESET_BASE) begin
            o_flags.ready = 1'b1;
        end else begin
            o_count         = cnt1;
            o_flags.removed = removed1;
            o_flags.ready   = 1'b1;
            o_flags.low     = low1;
            o_flags.locked  = locked1;
            o_flags.rise    = i_flags.rise || trig;
            o_flags.inhibit = inh1;
            o_baseline      = base2;
            o_hold          = hold1;
            if (hold1 != '0) begin
                o_hold = hold2;
                if (hold2 == '0) begin
                    o_flags.inhibit = 1'b0;
                    if (locked1) begin
                        if (chk <= rth) begin
                            o_flags.locked = 1'b0;
                            o_flags.rise   = 1'b0;
                            o_baseline     = i_phase;
                        end else begin
                            o_flags.inhibit = 1'b1;
                            o_hold          = i_cfg.inhibit_length;
                        end
                    end
                end
            end
            o_flags.warn = (cnt1 != '0) && !removed1;
        end
    end

endmodule
`default_nettype wire

### src/pam_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pam_checker
// Port-level assertions for the phase anomaly monitor, bound to the top.
// ----------------------------------------------------------------------------
module pam_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_stall,
    input wire logic                               i_op,
    input wire logic signed [pam_pkg::PHASE_W-1:0] i_phase,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_stall,
    input wire logic                               o_removed_flag,
    input wire logic                               o_warn_flag,
    input wire logic                               o_rise_flag,
    input wire logic                               o_inhibit_flag,
    input wire logic                               o_locked_flag,
    input wire logic                               o_ready_flag,
    input wire logic signed [pam_pkg::PHASE_W-1:0] o_baseline_out
);

    // stalled sample holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_op) && $stable(i_phase))
        else $error("stalled sample changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_baseline_out)
            && $stable(o_removed_flag) && $stable(o_locked_flag))
        else $error("stalled result changed");

    // every item leaves the baseline initialized
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_ready_flag)
        else $error("result without ready flag");

    // warning and confirmed removal are exclusive
    a_warn_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_removed_flag && o_warn_flag))
        else $error("warn and removed both set");

    // a rise locks the baseline, and a locked baseline keeps the inhibit
    a_rise_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_rise_flag || o_locked_flag) |-> o_locked_flag && o_inhibit_flag)
        else $error("rise or lock without lock and inhibit");

endmodule

bind phase_anomaly_monitor pam_checker u_pam_checker (.*);
`default_nettype wire

### dv/pam_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pam_result_checker
// Watches the sample, result and register channels of the phase anomaly
// monitor, keeps its own copy of the monitor state, and compares every result
// transfer field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module pam_result_checker #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_stall,
    input  wire logic                               i_op,
    input  wire logic signed [pam_pkg::PHASE_W-1:0] i_phase,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic                               i_removed_flag,
    input  wire logic                               i_warn_flag,
    input  wire logic                               i_rise_flag,
    input  wire logic                               i_inhibit_flag,
    input  wire logic                               i_low_flag,
    input  wire logic                               i_locked_flag,
    input  wire logic                               i_ready_flag,
    input  wire logic signed [pam_pkg::PHASE_W-1:0] i_baseline_out,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_ready,
    input  wire logic [pam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pam_pkg::PHASE_W-1:0]        i_cfg_data,
    output int                                      o_fail_count,
    output int                                      o_pending
);

    localparam int unsigned PW = pam_pkg::PHASE_W;

    typedef struct packed {
        pam_pkg::t_flags           flags;
        logic signed [PW-1:0]      base;
    } t_monitor_result;

    // register copy
    logic signed [PW-1:0]              lim_level;
    logic        [PW-1:0]              confirm_len;
    logic signed [PW-1:0]              rise_thr;
    logic        [PW-1:0]              hold_len;
    logic        [pam_pkg::GAIN_W-1:0] gain;
    logic signed [PW-1:0]              low_lvl;

    // monitor state copy
    logic signed [PW-1:0]      base;
    logic [COUNT_WIDTH-1:0]    over_run;
    logic [PW-1:0]             hold;
    pam_pkg::t_flags           fl;

    t_monitor_result expected_q[$];
    t_monitor_result exp_r;
    int              fails = 0;

    function automatic t_monitor_result predict_result(input logic op,
                                                       input logic signed [PW-1:0] ph);
        logic signed [PW-1:0]      delta;
        logic signed [PW-1:0]      chk;
        longint                    prod;
        longint                    q;
        t_monitor_result           res;
        if (op == pam_pkg::OP_RESET_BASE) begin
            base     = ph;
            hold     = '0;
            fl       = '0;
            fl.ready = 1'b1;
        end else begin
            if (ph >= lim_level) begin
                if (over_run != '1) over_run = over_run + COUNT_WIDTH'(1);
                if (over_run >= confirm_len) fl.removed = 1'b1;
            end else begin
                over_run   = '0;
                fl.removed = 1'b0;
            end
            if (!fl.ready) begin
                base     = ph;
                fl.ready = 1'b1;
            end
            delta = ph - base;
            if (!fl.locked && delta > rise_thr) begin
                fl.locked  = 1'b1;
                fl.rise    = 1'b1;
                fl.inhibit = 1'b1;
                hold       = hold_len;
            end
            // q12 low-pass, floor division by arithmetic shift
            if (!fl.locked) begin
                prod = longint'(delta) * longint'(gain);
                q    = prod >>> pam_pkg::GAIN_FRAC;
                base = base + q[PW-1:0];
            end
            if (ph < low_lvl) begin
                fl.low     = 1'b1;
                fl.inhibit = 1'b1;
                hold       = hold_len;
            end else begin
                fl.low = 1'b0;
            end
            if (hold != '0) begin
                hold = hold - PW'(1);
                if (hold == '0) begin
                    fl.inhibit = 1'b0;
                    if (fl.locked) begin
                        chk = ph - base;
                        if (chk <= rise_thr) begin
                            fl.locked = 1'b0;
                            fl.rise   = 1'b0;
                            base      = ph;
                        end else begin
                            fl.inhibit = 1'b1;
                            hold       = hold_len;
                        end
                    end
                end
            end
            fl.warn = (over_run != '0) && !fl.removed;
        end
        res.flags = fl;
        res.base  = base;
        return res;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (act_v != exp_v) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_level   = pam_pkg::RST_OVER_LIMIT_LEVEL;
            confirm_len = pam_pkg::RST_CONFIRM_COUNT;
            rise_thr    = pam_pkg::RST_RISE_THRESHOLD;
            hold_len    = pam_pkg::RST_INHIBIT_LENGTH;
            gain        = pam_pkg::RST_FILTER_GAIN;
            low_lvl     = pam_pkg::RST_LOW_LEVEL;
            base        = '0;
            over_run    = '0;
            hold        = '0;
            fl          = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pam_pkg::CFG_OVER_LIMIT_LEVEL: lim_level   = i_cfg_data;
                    pam_pkg::CFG_CONFIRM_COUNT:    confirm_len = i_cfg_data;
                    pam_pkg::CFG_RISE_THRESHOLD:   rise_thr    = i_cfg_data;
                    pam_pkg::CFG_INHIBIT_LENGTH:   hold_len    = i_cfg_data;
                    pam_pkg::CFG_FILTER_GAIN:      gain = i_cfg_data[pam_pkg::GAIN_W-1:0];
                    pam_pkg::CFG_LOW_LEVEL:        low_lvl     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(predict_result(i_op, i_phase));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with none pending, expected none, actual baseline %0d",
                             $time, i_baseline_out);
                end else begin
                    exp_r = expected_q.pop_front();
                    check_field("removed_flag", int'(exp_r.flags.removed), int'(i_removed_flag));
                    check_field("warn_flag", int'(exp_r.flags.warn), int'(i_warn_flag));
                    check_field("rise_flag", int'(exp_r.flags.rise), int'(i_rise_flag));
                    check_field("inhibit_flag", int'(exp_r.flags.inhibit), int'(i_inhibit_flag));
                    check_field("low_flag", int'(exp_r.flags.low), int'(i_low_flag));
                    check_field("locked_flag", int'(exp_r.flags.locked), int'(i_locked_flag));
                    check_field("ready_flag", int'(exp_r.flags.ready), int'(i_ready_flag));
                    check_field("baseline_out", int'(exp_r.base), int'(i_baseline_out));
                end
            end
        end
        o_pending    = expected_q.size();
        o_fail_count = fails;
    end

endmodule

### dv/tb_phase_anomaly_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phase_anomaly_monitor
// Drives phase samples and register writes into the phase anomaly monitor,
// with random sender gaps and receiver stalls; a checker beside the block
// predicts each result and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_phase_anomaly_monitor;

    localparam int unsigned CNT_W = 16;
    localparam int unsigned PW    = pam_pkg::PHASE_W;

    // stimulus side, all known from time zero
    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic                              i_op        = pam_pkg::OP_SAMPLE;
    logic signed [PW-1:0]              i_phase     = '0;
    logic                              i_out_stall = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic [pam_pkg::CFG_IDX_W-1:0]     i_cfg_index = pam_pkg::CFG_OVER_LIMIT_LEVEL;
    logic [PW-1:0]                     i_cfg_data  = '0;

    // block outputs
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic                      o_removed_flag;
    logic                      o_warn_flag;
    logic                      o_rise_flag;
    logic                      o_inhibit_flag;
    logic                      o_low_flag;
    logic                      o_locked_flag;
    logic                      o_ready_flag;
    logic signed [PW-1:0]      o_baseline_out;
    logic                      o_cfg_ready;

    int fail_count;
    int pending_results;

    // random idling on both channels while set
    bit idle_on = 1'b0;

    // phase trajectory of the random part and the levels it steers around
    int level   = 500;
    int lim_now = 1000;
    int low_now = 300;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    phase_anomaly_monitor #(
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_phase        (i_phase),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_removed_flag (o_removed_flag),
        .o_warn_flag    (o_warn_flag),
        .o_rise_flag    (o_rise_flag),
        .o_inhibit_flag (o_inhibit_flag),
        .o_low_flag     (o_low_flag),
        .o_locked_flag  (o_locked_flag),
        .o_ready_flag   (o_ready_flag),
        .o_baseline_out (o_baseline_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    pam_result_checker #(
        .COUNT_WIDTH (CNT_W)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_phase        (i_phase),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_removed_flag (o_removed_flag),
        .i_warn_flag    (o_warn_flag),
        .i_rise_flag    (o_rise_flag),
        .i_inhibit_flag (o_inhibit_flag),
        .i_low_flag     (o_low_flag),
        .i_locked_flag  (o_locked_flag),
        .i_ready_flag   (o_ready_flag),
        .i_baseline_out (o_baseline_out),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results)
    );

    // receiver stalls in random bursts while idling is on, one assignment per edge
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // one sample transfer; entered and left at a falling edge, valid stays
    // high into the next item unless a gap lowers it
    task automatic send_sample(input logic op, input logic signed [PW-1:0] ph);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_phase    <= ph;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // hold the sender off until every predicted result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
    endtask

    task automatic write_reg(input logic [pam_pkg::CFG_IDX_W-1:0] idx,
                             input logic [PW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // full register set, written only once the block has gone idle
    task automatic load_settings(input int lim, input int confirm, input int rise,
                                 input int hold_len, input int gain, input int low);
        wait_drained();
        write_reg(pam_pkg::CFG_OVER_LIMIT_LEVEL, PW'(lim));
        write_reg(pam_pkg::CFG_CONFIRM_COUNT, PW'(confirm));
        write_reg(pam_pkg::CFG_RISE_THRESHOLD, PW'(rise));
        write_reg(pam_pkg::CFG_INHIBIT_LENGTH, PW'(hold_len));
        write_reg(pam_pkg::CFG_FILTER_GAIN, PW'(gain));
        write_reg(pam_pkg::CFG_LOW_LEVEL, PW'(low));
        lim_now = int'($signed(PW'(lim)));
        low_now = int'($signed(PW'(low)));
    endtask

    // settings of a random phase: plausible values, corner values, or noise
    task automatic pick_settings(input int mode);
        case (mode)
            0: load_settings($urandom_range(700, 1500), $urandom_range(0, 12),
                             $urandom_range(0, 300), $urandom_range(0, 30),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(4097, 8191)
                                                         : $urandom_range(0, 4096),
                             $urandom_range(100, 600));
            1: load_settings(($urandom_range(0, 1) == 0) ? -32768 : 32767,
                             ($urandom_range(0, 1) == 0) ? 0 : 65535,
                             ($urandom_range(0, 1) == 0) ? -32768 : 32767,
                             ($urandom_range(0, 1) == 0) ? 1 : 65535,
                             ($urandom_range(0, 1) == 0) ? 0 : 8191,
                             ($urandom_range(0, 1) == 0) ? -32768 : 32767);
            default: load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 8191), $urandom_range(0, 65535));
        endcase
    endtask

    // mostly a drifting phase that wanders through the thresholds: steps up
    // to provoke a rise, dips under the low level, runs over the limit; the
    // rest is baseline reloads and raw noise over the full range
    task automatic run_phase(input int n_items);
        int  r;
        logic op;
        for (int k = 0; k < n_items; k++) begin
            r  = $urandom_range(0, 99);
            op = pam_pkg::OP_SAMPLE;
            if (r < 3) begin
                op = pam_pkg::OP_RESET_BASE;
            end else if (r < 10) begin
                level = int'($urandom_range(0, 65535)) - 32768;
            end else if (r < 18) begin
                level = level + int'($urandom_range(50, 600));
            end else if (r < 26) begin
                level = low_now - int'($urandom_range(1, 200));
            end else if (r < 36) begin
                level = lim_now + int'($urandom_range(0, 300));
            end else begin
                level = level + int'($urandom_range(0, 80)) - 40;
            end
            if (level > 32767) level = 32767;
            if (level < -32768) level = -32768;
            // now and then let the pipeline run completely dry
            if ($urandom_range(0, 59) == 0) wait_drained();
            send_sample(op, PW'(level));
        end
    endtask

    initial begin
        // reset held low from time zero, released at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items at the reset settings
        send_sample(pam_pkg::OP_SAMPLE, 500);        // first sample becomes the baseline
        send_sample(pam_pkg::OP_SAMPLE, 550);
        send_sample(pam_pkg::OP_SAMPLE, 700);        // rise past the threshold locks
        send_sample(pam_pkg::OP_SAMPLE, 200);        // below the low level
        send_sample(pam_pkg::OP_SAMPLE, 1200);       // over limit, warning only
        send_sample(pam_pkg::OP_SAMPLE, 900);        // run broken
        send_sample(pam_pkg::OP_RESET_BASE, -32768);
        send_sample(pam_pkg::OP_SAMPLE, 32767);      // difference wraps around
        send_sample(pam_pkg::OP_RESET_BASE, 32767);
        send_sample(pam_pkg::OP_SAMPLE, -32768);

        // zero hold length keeps inhibit up
        load_settings(1000, 10, 100, 0, 41, 300);
        send_sample(pam_pkg::OP_RESET_BASE, 500);
        send_sample(pam_pkg::OP_SAMPLE, 100);
        send_sample(pam_pkg::OP_SAMPLE, 600);
        send_sample(pam_pkg::OP_SAMPLE, 600);

        // zero confirm count, any over-limit sample confirms
        load_settings(1000, 0, 100, 50, 41, 300);
        send_sample(pam_pkg::OP_SAMPLE, 2000);

        // raising the confirm count mid-run leaves removal set
        load_settings(1000, 2, 100, 50, 41, 300);
        send_sample(pam_pkg::OP_SAMPLE, 1200);
        send_sample(pam_pkg::OP_SAMPLE, 1200);
        send_sample(pam_pkg::OP_SAMPLE, 1200);
        wait_drained();
        write_reg(pam_pkg::CFG_CONFIRM_COUNT, 100);
        send_sample(pam_pkg::OP_SAMPLE, 1200);

        // gain above unity, baseline wraps
        load_settings(1000, 10, 32767, 50, 8191, -32768);
        send_sample(pam_pkg::OP_RESET_BASE, 0);
        send_sample(pam_pkg::OP_SAMPLE, 30000);
        send_sample(pam_pkg::OP_SAMPLE, -30000);

        // long over-limit run under a large confirm count only warns; a
        // baseline reload clears the flags but keeps the count, so the next
        // samples keep warning
        load_settings(-32768, 65535, 32767, 0, 0, -32768);
        repeat (20) send_sample(pam_pkg::OP_SAMPLE, 1);
        send_sample(pam_pkg::OP_RESET_BASE, 1);
        send_sample(pam_pkg::OP_SAMPLE, 1);
        send_sample(pam_pkg::OP_SAMPLE, 1);

        // random phases; the last one runs without any idling
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                load_settings(int'(pam_pkg::RST_OVER_LIMIT_LEVEL),
                              int'(pam_pkg::RST_CONFIRM_COUNT),
                              int'(pam_pkg::RST_RISE_THRESHOLD),
                              int'(pam_pkg::RST_INHIBIT_LENGTH),
                              int'(pam_pkg::RST_FILTER_GAIN),
                              int'(pam_pkg::RST_LOW_LEVEL));
            end else begin
                pick_settings(ph % 3);
            end
            idle_on = (ph < 9) && ($urandom_range(0, 3) != 0);
            level   = low_now + int'($urandom_range(0, 400));
            run_phase(85);
        end

        // drain and let the pipeline settle before the verdict
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
src/pam_pkg.sv
src/pam_cfg_regs.sv
src/pam_update.sv
src/phase_anomaly_monitor.sv
src/pam_checker.sv
dv/pam_result_checker.sv
dv/tb_phase_anomaly_monitor.sv
